// ===== src/sme_pkg.sv =====
// Package for the stack machine executor: constants, codes and controller types.
`default_nettype none
package sme_pkg;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int NUM_VARS_DEF    = 64;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 48;
    localparam int IN_W            = 48;
    localparam int MODE_W          = 4;
    localparam int IDX_W           = 6;
    localparam int CODE_W          = 3;

    localparam logic [MODE_W-1:0] OP_PUSH  = 4'd0;
    localparam logic [MODE_W-1:0] OP_LOAD  = 4'd1;
    localparam logic [MODE_W-1:0] OP_STORE = 4'd2;
    localparam logic [MODE_W-1:0] OP_ADD   = 4'd3;
    localparam logic [MODE_W-1:0] OP_SUB   = 4'd4;
    localparam logic [MODE_W-1:0] OP_MUL   = 4'd5;
    localparam logic [MODE_W-1:0] OP_DIV   = 4'd6;
    localparam logic [MODE_W-1:0] OP_SHL   = 4'd7;
    localparam logic [MODE_W-1:0] OP_PRINT = 4'd8;

    localparam logic [CODE_W-1:0] ERR_UNDERFLOW = 3'd0;
    localparam logic [CODE_W-1:0] ERR_UNDEF     = 3'd1;
    localparam logic [CODE_W-1:0] ERR_ZERO_DIV  = 3'd2;
    localparam logic [CODE_W-1:0] ERR_NEG_SHIFT = 3'd3;
    localparam logic [CODE_W-1:0] ERR_OVERFLOW  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_EXEC, ST_WAIT, ST_WRITE, ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;   // latch the incoming request
        logic       rd_stack;  // start memory reads of the stack top
        logic       exec;      // decode and start the operation
        logic       commit;    // write back the stack and variables
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       busy;      // operand reads or a multi-cycle unit still running
        logic       has_out;   // this request yields a result
    } t_sts;
endpackage
`default_nettype wire

// ===== src/sme_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module sme_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/sme_ctrl.sv =====
// Controller state machine sequencing one request through the datapath.
`default_nettype none
module sme_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    input  sme_pkg::t_sts  i_sts,
    output sme_pkg::t_cmd  o_cmd
);
    sme_pkg::t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sme_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sme_pkg::ST_IDLE:  if (i_in_valid) n_state = sme_pkg::ST_READ;
            sme_pkg::ST_READ:  n_state = sme_pkg::ST_EXEC;
            sme_pkg::ST_EXEC:  n_state = sme_pkg::ST_WAIT;
            sme_pkg::ST_WAIT:  if (!i_sts.busy) n_state = sme_pkg::ST_WRITE;
            sme_pkg::ST_WRITE: n_state = i_sts.has_out ? sme_pkg::ST_OUT : sme_pkg::ST_IDLE;
            sme_pkg::ST_OUT:   if (i_out_ready) n_state = sme_pkg::ST_IDLE;
            default:           n_state = sme_pkg::ST_IDLE;
        endcase
    end

    // Output decode.
    always_comb begin
        o_in_ready   = (r_state == sme_pkg::ST_IDLE);
        o_out_valid  = (r_state == sme_pkg::ST_OUT);
        o_cmd.capture  = (r_state == sme_pkg::ST_IDLE) && i_in_valid;
        o_cmd.rd_stack = (r_state == sme_pkg::ST_READ);
        o_cmd.exec     = (r_state == sme_pkg::ST_EXEC);
        o_cmd.commit   = (r_state == sme_pkg::ST_WRITE);
    end
endmodule
`default_nettype wire

// ===== src/sme_dp.sv =====
// Datapath: stack and variable memories, arithmetic and error checks.
`default_nettype none
module sme_dp #(
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
    parameter int NUM_VARS    = sme_pkg::NUM_VARS_DEF,
    parameter int FRAC_BITS   = sme_pkg::FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = sme_pkg::VALUE_WIDTH_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  sme_pkg::t_cmd                 i_cmd,
    output sme_pkg::t_sts                 o_sts,
    input  wire [sme_pkg::MODE_W-1:0]     i_mode,
    input  wire signed [sme_pkg::IN_W-1:0] i_const,
    input  wire [sme_pkg::IDX_W-1:0]      i_idx,
    input  wire                           i_first,
    output logic                          o_kind,
    output logic signed [sme_pkg::IN_W-1:0] o_value,
    output logic [sme_pkg::CODE_W-1:0]    o_code
);
    localparam int VW  = VALUE_WIDTH;
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int DW  = $clog2(STACK_DEPTH + 1);
    localparam int VAW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int VD  = (NUM_VARS > 1) ? NUM_VARS : 2;
    localparam int NW  = VW + FRAC_BITS;           // dividend width
    localparam int CW  = $clog2(NW + 1);
    localparam int HW  = 32;                       // multiplier half width
    localparam logic [VW-1:0] SMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] SMIN = {1'b1, {(VW-1){1'b0}}};
    localparam longint ZTHR = ((64'd1 << FRAC_BITS) - 64'd1) / 64'd1000000000;

    // Request latch.
    logic [sme_pkg::MODE_W-1:0] r_mode;
    logic [sme_pkg::IN_W-1:0]   r_const;
    logic [sme_pkg::IDX_W-1:0]  r_idx;
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_const <= i_const;
            r_idx   <= i_idx;
        end
    end

    // Control state: depth, halt flag, defined marks.
    logic [DW-1:0]  r_depth;
    logic           r_halted;
    logic [VD-1:0]  r_def;
    logic           r_skip;

    // Memories.
    logic           stk_we, var_we;
    logic [SAW-1:0] stk_waddr, stk_raddr;
    logic [VW-1:0]  stk_wdata, stk_rdata, var_rdata;
    logic [VAW-1:0] var_addr;
    logic [VW-1:0]  r_a, r_b;
    logic           r_rd_sel;

    sme_ram #(.WIDTH(VW), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );
    sme_ram #(.WIDTH(VW), .DEPTH(VD)) u_vars (
        .i_clk(i_clk), .i_we(var_we), .i_waddr(var_addr), .i_wdata(r_b),
        .i_raddr(var_addr), .o_rdata(var_rdata)
    );

    assign var_addr = r_idx[VAW-1:0];
    logic idx_ok;
    assign idx_ok = (NUM_VARS > 1) ? ({26'd0, r_idx} < 32'(NUM_VARS)) : (r_idx == '0);

    // Read addresses: top first (into r_b), then next (into r_a).
    always_comb begin
        if (r_rd_sel) begin
            stk_raddr = SAW'(r_depth - DW'(2));
        end else begin
            stk_raddr = SAW'(r_depth - DW'(1));
        end
    end

    // Read sequence: top data in step one, next data in step two, both
    // operands held from step three, when the arithmetic units start.
    logic [1:0] r_rcnt;
    logic       start;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_sel <= 1'b0;
            r_rcnt   <= '0;
        end else if (i_cmd.rd_stack) begin
            r_rd_sel <= 1'b1;
            r_rcnt   <= 2'd1;
        end else if (r_rcnt == 2'd1) begin
            r_rd_sel <= 1'b0;
            r_rcnt   <= 2'd2;
        end else if (r_rcnt == 2'd2) begin
            r_rcnt   <= 2'd3;
        end else begin
            r_rcnt   <= '0;
        end
    end
    assign start = (r_rcnt == 2'd3);

    // Capture read data: top into r_b while r_rcnt is 1, next into r_a while it is 2.
    always_ff @(posedge i_clk) begin
        if (r_rcnt == 2'd1) r_b <= stk_rdata;
        if (r_rcnt == 2'd2) r_a <= stk_rdata;
    end

    // Helpers on magnitudes.
    function automatic logic [VW-1:0] mag(input logic [VW-1:0] v);
        mag = v[VW-1] ? (~v + VW'(1)) : v;
    endfunction
    function automatic logic [VW-1:0] sat(input logic neg, input logic big,
                                          input logic [VW-1:0] m);
        if (neg) begin
            sat = (big || m > SMIN) ? SMIN : (~m + VW'(1));
        end else begin
            sat = (big || m > SMAX) ? SMAX : m;
        end
    endfunction

    // Constant saturated into the value width.
    logic           c_neg;
    logic [sme_pkg::IN_W-1:0] c_mag;
    logic           c_big;
    logic [VW-1:0]  c_val;
    always_comb begin
        c_neg = r_const[sme_pkg::IN_W-1];
        c_mag = c_neg ? (~r_const + 48'd1) : r_const;
        if (VW >= sme_pkg::IN_W) begin
            c_big = 1'b0;
            c_val = sat(c_neg, 1'b0, VW'(c_mag));
        end else begin
            c_big = (c_mag >> (VW >= sme_pkg::IN_W ? 0 : VW)) != '0;
            c_val = sat(c_neg, c_big, VW'(c_mag));
        end
    end

    // Sequential multiplier: four 32x32 partial products, one per cycle.
    logic [2*HW-1:0] ma_ext, mb_ext;
    logic [2:0]      r_mstep;
    logic            r_mbusy;
    logic [HW-1:0]   mx, my;
    logic [2*HW-1:0] r_pp;
    logic [2:0]      r_pstep;
    logic            r_pvalid;
    assign ma_ext = 64'(mag(r_a));
    assign mb_ext = 64'(mag(r_b));
    always_comb begin
        unique case (r_mstep[1:0])
            2'd0: begin mx = ma_ext[HW-1:0];   my = mb_ext[HW-1:0];   end
            2'd1: begin mx = ma_ext[HW-1:0];   my = mb_ext[2*HW-1:HW]; end
            2'd2: begin mx = ma_ext[2*HW-1:HW]; my = mb_ext[HW-1:0];   end
            default: begin mx = ma_ext[2*HW-1:HW]; my = mb_ext[2*HW-1:HW]; end
        endcase
    end
    logic [127:0] pp_sh;
    always_comb begin
        unique case (r_pstep[1:0])
            2'd0:    pp_sh = 128'(r_pp);
            2'd1:    pp_sh = 128'(r_pp) << HW;
            2'd2:    pp_sh = 128'(r_pp) << HW;
            default: pp_sh = 128'(r_pp) << (2 * HW);
        endcase
    end
    logic [127:0] r_acc;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy  <= 1'b0;
            r_pvalid <= 1'b0;
        end else if (start && r_mode == sme_pkg::OP_MUL) begin
            r_mbusy  <= 1'b1;
            r_mstep  <= '0;
            r_pvalid <= 1'b0;
            r_acc    <= '0;
        end else if (r_mbusy) begin
            r_pp     <= mx * my;
            r_pstep  <= r_mstep;
            r_pvalid <= r_mstep < 3'd4;
            if (r_mstep < 3'd4) r_mstep <= r_mstep + 3'd1;
            if (r_pvalid) r_acc <= r_acc + pp_sh;
            if (r_pvalid && r_pstep == 3'd3) r_mbusy <= 1'b0;
        end
    end

    // Sequential restoring divider: one quotient bit per cycle.
    logic [NW-1:0]  r_dnum;
    logic [VW:0]    r_rem;
    logic [NW-1:0]  r_quo;
    logic [CW-1:0]  r_dcnt;
    logic           r_dbusy;
    logic [VW:0]    rem_sh;
    logic [VW-1:0]  dmag;
    assign dmag   = mag(r_b);
    assign rem_sh = {r_rem[VW-1:0], r_dnum[NW-1]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
        end else if (start && r_mode == sme_pkg::OP_DIV) begin
            r_dbusy <= 1'b1;
            r_dnum  <= NW'(mag(r_a)) << FRAC_BITS;
            r_rem   <= '0;
            r_quo   <= '0;
            r_dcnt  <= CW'(NW);
        end else if (r_dbusy) begin
            r_dnum <= r_dnum << 1;
            if (rem_sh >= {1'b0, dmag}) begin
                r_rem <= rem_sh - {1'b0, dmag};
                r_quo <= {r_quo[NW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[NW-2:0], 1'b0};
            end
            r_dcnt <= r_dcnt - CW'(1);
            if (r_dcnt == CW'(1)) r_dbusy <= 1'b0;
        end
    end

    // Busy while the operands are still being read or a unit is running.
    assign o_sts.busy = r_mbusy || r_dbusy || i_cmd.exec || (r_rcnt != 2'd0);

    // Rounding to integer magnitude (used by shift).
    function automatic logic [VW-1:0] rnd(input logic [VW-1:0] v);
        logic [VW:0] s;
        s = {1'b0, mag(v)} + ((FRAC_BITS > 0) ? ((VW+1)'(1) << (FRAC_BITS - 1)) : '0);
        rnd = VW'(s >> FRAC_BITS);
    endfunction

    // Execute: checks and results, committed at the write step.
    logic           neg_a, neg_b;
    logic [VW-1:0]  res, sum, dif;
    logic           err, has_out;
    logic [sme_pkg::CODE_W-1:0] code;
    logic [DW-1:0]  n_depth;
    logic           push, do_store;
    logic [VW-1:0]  sa, sb;
    logic [127:0]   prnd;
    logic [127:0]   pq;
    logic [127:0]   shv;
    logic [7:0]     sh_tot;
    always_comb begin
        neg_a = r_a[VW-1];
        neg_b = r_b[VW-1];
        sum   = r_a + r_b;
        dif   = r_a - r_b;
        res   = '0;
        err   = 1'b0;
        code  = sme_pkg::ERR_UNDERFLOW;
        has_out = 1'b0;
        push  = 1'b0;
        do_store = 1'b0;
        n_depth = r_depth;
        sa    = rnd(r_a);
        sb    = rnd(r_b);
        prnd  = (r_acc + ((FRAC_BITS > 0) ? (128'd1 << (FRAC_BITS - 1)) : 128'd0)) >> FRAC_BITS;
        pq    = 128'(r_quo);
        sh_tot = 8'(sb) + 8'(FRAC_BITS);
        shv   = 128'(sa) << sh_tot;
        unique case (r_mode)
            sme_pkg::OP_PUSH: begin
                if (r_depth >= DW'(STACK_DEPTH)) begin
                    err = 1'b1; code = sme_pkg::ERR_OVERFLOW;
                end else begin
                    push = 1'b1; res = c_val;
                end
            end
            sme_pkg::OP_LOAD: begin
                if (!idx_ok || !r_def[var_addr]) begin
                    err = 1'b1; code = sme_pkg::ERR_UNDEF;
                end else if (r_depth >= DW'(STACK_DEPTH)) begin
                    err = 1'b1; code = sme_pkg::ERR_OVERFLOW;
                end else begin
                    push = 1'b1; res = var_rdata;
                end
            end
            sme_pkg::OP_STORE, sme_pkg::OP_PRINT: begin
                if (r_depth == '0) begin
                    err = 1'b1;
                end else begin
                    n_depth  = r_depth - DW'(1);
                    do_store = (r_mode == sme_pkg::OP_STORE) && idx_ok;
                    has_out  = (r_mode == sme_pkg::OP_PRINT);
                end
            end
            sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL,
            sme_pkg::OP_DIV, sme_pkg::OP_SHL: begin
                if (r_depth < DW'(2)) begin
                    err = 1'b1;
                end else begin
                    n_depth = r_depth - DW'(1);
                    push    = 1'b1;
                    unique case (r_mode)
                        sme_pkg::OP_ADD: res = (neg_a == neg_b && sum[VW-1] != neg_a)
                                               ? (neg_a ? SMIN : SMAX) : sum;
                        sme_pkg::OP_SUB: res = (neg_a != neg_b && dif[VW-1] != neg_a)
                                               ? (neg_a ? SMIN : SMAX) : dif;
                        sme_pkg::OP_MUL: res = sat(neg_a ^ neg_b,
                                               (prnd >> VW) != '0, VW'(prnd));
                        sme_pkg::OP_DIV: begin
                            if (64'(dmag) <= 64'(ZTHR)) begin
                                err = 1'b1; code = sme_pkg::ERR_ZERO_DIV;
                            end
                            res = sat(neg_a ^ neg_b, (pq >> VW) != '0, VW'(pq));
                        end
                        default: begin
                            if (neg_b && sb != '0) begin
                                err = 1'b1; code = sme_pkg::ERR_NEG_SHIFT;
                            end
                            if (sa == '0) begin
                                res = '0;
                            end else begin
                                res = sat(neg_a, (64'(sb) >= 64'd64) || (sh_tot >= 8'd64)
                                          || ((shv >> 64) != '0) || ((shv >> VW) != '0),
                                          VW'(shv));
                            end
                        end
                    endcase
                    if (err) push = 1'b0;
                end
            end
            default: begin
            end
        endcase
        if (r_skip) begin
            err = 1'b0; push = 1'b0; do_store = 1'b0; has_out = 1'b0;
            n_depth = r_depth;
        end
        if (err) begin
            push = 1'b0; do_store = 1'b0; n_depth = r_depth; has_out = 1'b1;
        end else if (push && r_mode <= sme_pkg::OP_LOAD) begin
            n_depth = r_depth + DW'(1);
        end
    end
    assign o_sts.has_out = has_out;

    assign stk_we    = i_cmd.commit && push;
    assign stk_waddr = (r_mode <= sme_pkg::OP_LOAD) ? SAW'(r_depth) : SAW'(r_depth - DW'(2));
    assign stk_wdata = res;
    assign var_we    = i_cmd.commit && do_store;

    // Depth, halt and defined marks; first-of-program clears at capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= '0;
            r_halted <= 1'b0;
            r_def    <= '0;
            r_skip   <= 1'b0;
        end else if (i_cmd.capture) begin
            if (i_first) begin
                r_depth  <= '0;
                r_halted <= 1'b0;
                r_def    <= '0;
                r_skip   <= 1'b0;
            end else begin
                r_skip <= r_halted;
            end
        end else if (i_cmd.commit) begin
            r_depth <= n_depth;
            if (err) r_halted <= 1'b1;
            if (do_store) r_def[var_addr] <= 1'b1;
            o_kind  <= err;
            o_code  <= err ? code : '0;
            o_value <= err ? '0 : 48'(signed'(r_b));
        end
    end
endmodule
`default_nettype wire

// ===== src/stack_machine_executor.sv =====
// Top level of the stack machine executor.
// The block runs one bytecode instruction per input request on an operand
// stack of signed fixed-point values and a store of indexed variables.
// Input channel (s_axis): tdata carries mode, const_value and var_index,
// tuser carries the first-of-program flag. Output channel (m_axis): tdata
// carries print_value and error_code, tuser carries the kind.
// A request is taken only while the block is idle; each instruction passes
// through latch, two stack reads, execute and write-back. Mul forms four
// 32x32 partial products on one multiplier and div takes one quotient bit
// per cycle in the restoring divider; the block stays busy until they finish.
// A result is offered once the write-back is done, and the block is ready
// again in the cycle after it leaves. At most one result follows a request.
// An error reports once and the block then ignores requests until one with
// the first flag set.
// Reset clears the stack depth, the defined marks and the halt flag; the
// memories themselves are not cleared. When the receiver stalls the result
// is held in its register and no further request is taken until it leaves.
`default_nettype none
module stack_machine_executor #(
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
    parameter int NUM_VARS    = sme_pkg::NUM_VARS_DEF,
    parameter int FRAC_BITS   = sme_pkg::FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = sme_pkg::VALUE_WIDTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [63:0]  s_axis_tdata,   // mode[3:0], const_value[51:4], var_index[57:52]
    input  wire         s_axis_tuser,   // first
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata,   // print_value[47:0], error_code[50:48]
    output logic        m_axis_tuser    // kind
);
    sme_pkg::t_cmd cmd;
    sme_pkg::t_sts sts;
    logic [sme_pkg::IN_W-1:0]   value;
    logic [sme_pkg::CODE_W-1:0] code;

    sme_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_sts(sts), .o_cmd(cmd)
    );

    sme_dp #(
        .STACK_DEPTH(STACK_DEPTH), .NUM_VARS(NUM_VARS),
        .FRAC_BITS(FRAC_BITS), .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_mode(s_axis_tdata[3:0]), .i_const(s_axis_tdata[51:4]),
        .i_idx(s_axis_tdata[57:52]), .i_first(s_axis_tuser),
        .o_kind(m_axis_tuser), .o_value(value), .o_code(code)
    );

    assign m_axis_tdata = {5'd0, code, value};
endmodule
`default_nettype wire

// ===== tb/stack_machine_executor_checker.sv =====
// Checker for the stack machine executor: predicts each result and compares it.
`default_nettype none
module stack_machine_executor_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    input  wire [63:0]  s_axis_tdata,   // mode[3:0], const_value[51:4], var_index[57:52]
    input  wire         s_axis_tuser,   // first
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire [55:0]  m_axis_tdata,   // print_value[47:0], error_code[50:48]
    input  wire         m_axis_tuser,   // kind
    output int          o_failures,
    output int          o_pending,
    output int          o_prints,
    output int          o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [47:0] MAX_V = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] MIN_V = 48'h8000_0000_0000;

    typedef struct packed {
        logic        kind;
        logic [47:0] value;
        logic [2:0]  code;
    } t_outcome;

    t_outcome    awaited[$];
    logic [47:0] stack_mem[16];
    int          depth;
    logic [47:0] var_mem[64];
    bit          var_set[64];
    bit          stopped;

    // Magnitude of a signed value as an unsigned number.
    function automatic logic [127:0] mag_of(logic [47:0] v);
        logic [47:0] n;
        n = -v;
        return v[47] ? {80'b0, n} : {80'b0, v};
    endfunction

    // Rebuild a signed value from sign and magnitude, saturating.
    function automatic logic [47:0] saturate(bit neg, logic [127:0] m);
        logic [47:0] lo;
        if (neg) begin
            if (m > 128'h8000_0000_0000) return MIN_V;
            lo = m[47:0];
            return -lo;
        end
        if (m > 128'h7FFF_FFFF_FFFF) return MAX_V;
        return m[47:0];
    endfunction

    // Round a fixed-point magnitude to the nearest integer, ties away from zero.
    function automatic logic [127:0] to_int(logic [47:0] v);
        return (mag_of(v) + 128'h8000) >> 16;
    endfunction

    function automatic t_outcome report(logic [2:0] c);
        t_outcome o;
        o.kind = 1'b1;
        o.value = '0;
        o.code = c;
        stopped = 1;
        return o;
    endfunction

    // Execute one instruction; returns 1 when it yields a result.
    function automatic bit execute(logic [3:0] mode, logic [47:0] cval, logic [5:0] idx,
                                   bit first, output t_outcome o);
        logic [47:0]  a, b, r;
        logic [48:0]  s;
        logic [127:0] p, sh;
        if (first) begin
            depth = 0;
            foreach (var_set[i]) var_set[i] = 0;
            stopped = 0;
        end
        if (stopped || mode > sme_pkg::OP_PRINT) return 0;
        case (mode)
            sme_pkg::OP_PUSH: begin
                if (depth >= 16) begin o = report(sme_pkg::ERR_OVERFLOW); return 1; end
                stack_mem[depth] = cval;
                depth++;
                return 0;
            end
            sme_pkg::OP_LOAD: begin
                if (!var_set[idx]) begin o = report(sme_pkg::ERR_UNDEF); return 1; end
                if (depth >= 16) begin o = report(sme_pkg::ERR_OVERFLOW); return 1; end
                stack_mem[depth] = var_mem[idx];
                depth++;
                return 0;
            end
            sme_pkg::OP_STORE: begin
                if (depth < 1) begin o = report(sme_pkg::ERR_UNDERFLOW); return 1; end
                depth--;
                var_mem[idx] = stack_mem[depth];
                var_set[idx] = 1;
                return 0;
            end
            sme_pkg::OP_PRINT: begin
                if (depth < 1) begin o = report(sme_pkg::ERR_UNDERFLOW); return 1; end
                depth--;
                o.kind = 1'b0;
                o.value = stack_mem[depth];
                o.code = '0;
                return 1;
            end
            default: ;
        endcase
        if (depth < 2) begin o = report(sme_pkg::ERR_UNDERFLOW); return 1; end
        depth--;
        b = stack_mem[depth];
        depth--;
        a = stack_mem[depth];
        case (mode)
            sme_pkg::OP_ADD, sme_pkg::OP_SUB: begin
                if (mode == sme_pkg::OP_ADD) s = {a[47], a} + {b[47], b};
                else s = {a[47], a} - {b[47], b};
                r = (s[48] != s[47]) ? (s[48] ? MIN_V : MAX_V) : s[47:0];
            end
            sme_pkg::OP_MUL: begin
                p = (mag_of(a) * mag_of(b) + 128'h8000) >> 16;
                r = saturate(a[47] ^ b[47], p);
            end
            sme_pkg::OP_DIV: begin
                // Divisors below one nano are treated as zero; at 16 fraction bits only 0.
                if (b == '0) begin o = report(sme_pkg::ERR_ZERO_DIV); return 1; end
                p = (mag_of(a) << 16) / mag_of(b);
                r = saturate(a[47] ^ b[47], p);
            end
            default: begin
                sh = to_int(b);
                if (b[47] && sh != 0) begin
                    o = report(sme_pkg::ERR_NEG_SHIFT);
                    return 1;
                end
                p = to_int(a);
                if (p == 0) r = '0;
                else if (sh >= 64) r = a[47] ? MIN_V : MAX_V;
                else r = saturate(a[47], p << (sh + 16));
            end
        endcase
        stack_mem[depth] = r;
        depth++;
        return 0;
    endfunction

    // Predict on each accepted request, compare on each accepted result.
    always @(posedge i_clk) begin
        t_outcome o, e;
        if (!i_rst_n) begin
            awaited.delete();
            depth = 0;
            foreach (var_set[i]) var_set[i] = 0;
            stopped = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (execute(s_axis_tdata[3:0], s_axis_tdata[51:4], s_axis_tdata[57:52],
                            s_axis_tuser, o))
                    awaited.insert(awaited.size(), o);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (m_axis_tuser) o_errors++;
                else o_prints++;
                if (awaited.size() == 0) begin
                    $error("unexpected result: kind %0d value %h code %0d",
                           m_axis_tuser, m_axis_tdata[47:0], m_axis_tdata[50:48]);
                    o_failures++;
                end else begin
                    e = awaited.pop_front();
                    if (m_axis_tuser !== e.kind) begin
                        $error("kind: expected %0d, got %0d", e.kind, m_axis_tuser);
                        o_failures++;
                    end
                    if (m_axis_tdata[47:0] !== e.value) begin
                        $error("print_value: expected %h, got %h", e.value,
                               m_axis_tdata[47:0]);
                        o_failures++;
                    end
                    if (m_axis_tdata[50:48] !== e.code) begin
                        $error("error_code: expected %0d, got %0d", e.code,
                               m_axis_tdata[50:48]);
                        o_failures++;
                    end
                end
            end
        end
        o_pending = awaited.size();
    end
endmodule
`default_nettype wire

// ===== tb/stack_machine_executor_test.sv =====
// Top of the stack machine executor testbench: stimulus, watchdog and verdict.
`default_nettype none
module stack_machine_executor_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    wire         s_axis_tready;
    logic [63:0] s_axis_tdata;   // mode[3:0], const_value[51:4], var_index[57:52]
    logic        s_axis_tuser;   // first
    wire         m_axis_tvalid;
    logic        m_axis_tready;
    wire  [55:0] m_axis_tdata;   // print_value[47:0], error_code[50:48]
    wire         m_axis_tuser;   // kind

    int failures, pending, prints, errors;
    int idle_pct, stall_pct;
    int sent, quiet;

    stack_machine_executor dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
    );

    stack_machine_executor_checker checker_i (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .o_failures(failures), .o_pending(pending), .o_prints(prints), .o_errors(errors)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver stalls at random according to the current phase.
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // Watchdog on cycles with no request or result moving.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("stack_machine_executor_test NOT OK");
            $finish;
        end
    end

    // Offer one instruction and wait until it is taken; then, in an idling
    // phase, hold off until the block is ready and a per-cycle draw says go.
    task automatic issue(logic [3:0] mode, logic [47:0] cval, logic [5:0] idx, bit first);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, idx, cval, mode};
        s_axis_tuser <= first;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
        if (idle_pct != 0) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while (!s_axis_tready || $urandom_range(99) < idle_pct);
        end
    endtask

    // Random constant: extremes, small numbers, integers for shifts, or raw bits.
    function automatic logic [47:0] pick_value();
        logic [47:0] v;
        case ($urandom_range(5))
            0: v = 48'({$urandom, $urandom});
            1: v = $urandom_range(1) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
            2: v = 48'($urandom_range(40)) << 16;
            3: v = 48'($urandom_range(20)) << 15;
            4: v = 48'($urandom_range(3));
            default: v = 48'($urandom) << $urandom_range(16);
        endcase
        if ($urandom_range(3) == 0) v = -v;
        return v;
    endfunction

    function automatic logic [5:0] pick_slot();
        return ($urandom_range(4) == 0) ? 6'($urandom) : 6'($urandom_range(3));
    endfunction

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (100) @(posedge i_clk);
    endtask

    initial begin
        int w;
        logic [3:0] op;
        idle_pct = 0;
        stall_pct = 0;
        sent = 0;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: saturation at both ends, rounding shift, the error paths.
        issue(sme_pkg::OP_PUSH, 48'h7FFF_FFFF_FFFF, '0, 1'b1);
        issue(sme_pkg::OP_PUSH, 48'h1_0000, '0, 1'b0);
        issue(sme_pkg::OP_ADD, '0, '0, 1'b0);
        issue(sme_pkg::OP_PRINT, '0, '0, 1'b0);
        issue(sme_pkg::OP_PUSH, 48'h8000_0000_0000, '0, 1'b0);
        issue(sme_pkg::OP_PUSH, 48'h1_0000, '0, 1'b0);
        issue(sme_pkg::OP_SUB, '0, '0, 1'b0);
        issue(sme_pkg::OP_PUSH, 48'h2_0000, '0, 1'b0);
        issue(sme_pkg::OP_MUL, '0, '0, 1'b0);
        issue(sme_pkg::OP_PRINT, '0, '0, 1'b0);
        issue(sme_pkg::OP_PUSH, 48'h3_8000, '0, 1'b0);
        issue(sme_pkg::OP_PUSH, 48'h0_8000, '0, 1'b0);
        issue(sme_pkg::OP_SHL, '0, '0, 1'b0);
        issue(sme_pkg::OP_PUSH, 48'h0, '0, 1'b0);
        issue(sme_pkg::OP_DIV, '0, '0, 1'b0);          // divide by zero halts
        issue(sme_pkg::OP_PUSH, 48'h5, '0, 1'b0);      // ignored while halted
        issue(4'd15, '0, '0, 1'b1);                    // unused mode restarts and does nothing
        issue(sme_pkg::OP_LOAD, '0, 6'd63, 1'b0);      // undefined variable
        issue(sme_pkg::OP_PUSH, 48'hFFFF_FFFE_0000, '0, 1'b1);
        issue(sme_pkg::OP_STORE, '0, 6'd63, 1'b0);
        issue(sme_pkg::OP_LOAD, '0, 6'd63, 1'b0);
        issue(sme_pkg::OP_LOAD, '0, 6'd63, 1'b0);
        issue(sme_pkg::OP_SHL, '0, '0, 1'b0);          // negative shift amount
        issue(sme_pkg::OP_PRINT, '0, '0, 1'b1);        // underflow on an empty stack
        for (int i = 0; i < 17; i++)                   // last push overflows the stack
            issue(sme_pkg::OP_PUSH, 48'(i) << 16, '0, i == 0);
        wait_drained();

        // Random programs in four handshake phases, draining between them.
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 84 : (ph == 3) ? 35 : 0;
            stall_pct = (ph == 2) ? 84 : (ph == 3) ? 35 : 0;
            issue(sme_pkg::OP_PUSH, pick_value(), '0, 1'b1);
            for (int n = 0; n < 150; n++) begin
                w = $urandom_range(99);
                if (w < 28) op = sme_pkg::OP_PUSH;
                else if (w < 36) op = sme_pkg::OP_LOAD;
                else if (w < 44) op = sme_pkg::OP_STORE;
                else if (w < 80) op = 4'($urandom_range(sme_pkg::OP_ADD, sme_pkg::OP_SHL));
                else if (w < 95) op = sme_pkg::OP_PRINT;
                else op = 4'($urandom_range(9, 15));
                issue(op, pick_value(), pick_slot(), $urandom_range(14) == 0);
            end
            wait_drained();
        end

        $display("Sent %0d instructions over four handshake phases;", sent);
        $display("checked %0d prints and %0d error reports.", prints, errors);
        if (failures == 0)
            $display("stack_machine_executor_test OK");
        else
            $display("stack_machine_executor_test NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
src/sme_pkg.sv
src/sme_ram.sv
src/sme_ctrl.sv
src/sme_dp.sv
src/stack_machine_executor.sv
tb/stack_machine_executor_checker.sv
tb/stack_machine_executor_test.sv
